// ----- hdl/vertex_bake_transform_assert.svh -----
// Assertion macros for the vertex transform block.
// Included by the top level; expects clk and rst in the including scope.
`ifndef VERTEX_BAKE_TRANSFORM_ASSERT_SVH
`define VERTEX_BAKE_TRANSFORM_ASSERT_SVH
`ifndef SYNTHESIS
`define VBT_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("vertex_bake_transform: same-cycle check failed");
`define VBT_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("vertex_bake_transform: next-cycle check failed");
`else
`define VBT_ASSERT_NOW(lbl, pre, post)
`define VBT_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ----- hdl/vbt_pkg.sv -----
// Shared types and constants for the vertex transform block.
// No dependencies; every module and the testbench import this package.
package vbt_pkg;

  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned NUM_PAIRS   = 6;
  localparam int unsigned SQRT_STAGES = 32;
  localparam int unsigned QUOT_W      = 18;
  localparam int unsigned NUM_W       = 49;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAIR_0   = 3'd0,
    CFG_PAIR_1   = 3'd1,
    CFG_PAIR_2   = 3'd2,
    CFG_PAIR_3   = 3'd3,
    CFG_PAIR_4   = 3'd4,
    CFG_PAIR_5   = 3'd5,
    CFG_TWO_COMP = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SRC_XFORM   = 2'd0,
    SRC_INPUT   = 2'd1,
    SRC_DEFAULT = 2'd2
  } src_t;

  localparam logic        ACT_POSITION    = 1'b0;
  localparam logic [63:0] LENGTH_EPSILON  = 64'd43;
  localparam logic [31:0] Q16_ONE         = 32'h0001_0000;
  localparam logic [63:0] COEF_RESET_DIAG = 64'h0000_0000_0001_0000;

  typedef struct packed {
    logic             action;
    logic [2:0][31:0] pos;
    logic             sat;
    logic             d_ok;
    logic [5:0][31:0] comp;
  } xf_t;

  typedef struct packed {
    logic             action;
    logic [2:0][31:0] pos;
    logic             sat;
    logic [1:0]       ok;
    logic [5:0]       neg;
    logic [5:0][31:0] mag;
    logic [1:0][4:0]  shift;
  } item_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    src_t        src;
    logic        sat;
    logic        is_normal;
  } result_t;

endpackage

// ----- hdl/vbt_xform.sv -----
// Matrix multiply, rounding, translation and clamp: three register stages.
// Depends on vbt_pkg.
module vbt_xform (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic              action,
  input  logic [31:0]       in_x,
  input  logic [31:0]       in_y,
  input  logic [31:0]       in_z,
  input  logic [11:0][31:0] coef,
  input  logic              two_comp,
  output logic              out_valid,
  output vbt_pkg::xf_t      out_item
);
  import vbt_pkg::*;

  logic [2:0][31:0]       v_in;
  logic                   vld1, act1, vld2, act2;
  logic [2:0][31:0]       v1, v2;
  logic [2:0][2:0][63:0]  prod1;
  logic [2:0][49:0]       dot2;
  logic signed [65:0]     sum [3];
  logic signed [50:0]     tsum [3];
  logic [2:0][31:0]       pos_c;
  logic [2:0]             clamp_c, rng_c;

  always_comb begin
    v_in[0] = in_x;
    v_in[1] = in_y;
    v_in[2] = (action == ACT_POSITION && two_comp) ? 32'd0 : in_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld1 <= in_valid;
      vld2 <= vld1;
      out_valid <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act1 <= action;
      v1 <= v_in;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod1[r][c] <= $signed(coef[c*3+r]) * $signed(v_in[c]);
        end
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = 66'($signed(prod1[r][0])) + 66'($signed(prod1[r][1]))
             + 66'($signed(prod1[r][2])) + 66'sd32768;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act2 <= act1;
      v2 <= v1;
      for (int r = 0; r < 3; r++) begin
        dot2[r] <= sum[r][65:16];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      tsum[r] = 51'($signed(dot2[r])) + 51'($signed(coef[9+r]));
      rng_c[r] = (&dot2[r][49:31]) | ~(|dot2[r][49:31]);
      if (tsum[r] > 51'sd2147483647) begin
        pos_c[r] = 32'h7FFF_FFFF;
        clamp_c[r] = 1'b1;
      end else if (tsum[r] < -51'sd2147483648) begin
        pos_c[r] = 32'h8000_0000;
        clamp_c[r] = 1'b1;
      end else begin
        pos_c[r] = tsum[r][31:0];
        clamp_c[r] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item.action <= act2;
      out_item.pos <= pos_c;
      out_item.sat <= |clamp_c;
      out_item.d_ok <= &rng_c;
      for (int r = 0; r < 3; r++) begin
        out_item.comp[r] <= dot2[r][31:0];
        out_item.comp[r+3] <= v2[r];
      end
    end
  end

endmodule

// ----- hdl/vbt_len.sv -----
// Squared lengths, epsilon test and the normalising shift of both vectors.
// Depends on vbt_pkg; two stages followed by five shift stages.
module vbt_len (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  vbt_pkg::xf_t      in_item,
  output logic              out_valid,
  output vbt_pkg::item_t    out_item,
  output logic [1:0][63:0]  rad
);
  import vbt_pkg::*;

  localparam int unsigned SHIFT_STAGES = 5;

  logic             vld1, vld2;
  item_t            it1, it2, it2_next;
  logic [5:0][63:0] sq1;
  logic [1:0][63:0] len2, len2_next;

  logic [SHIFT_STAGES-1:0] vs;
  item_t                   its [SHIFT_STAGES];
  logic [1:0][63:0]        ts  [SHIFT_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
    end else if (en) begin
      vld1 <= in_valid;
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1.action <= in_item.action;
      it1.pos <= in_item.pos;
      it1.sat <= in_item.sat;
      it1.ok <= {1'b1, in_item.d_ok};
      it1.shift <= '0;
      for (int i = 0; i < 6; i++) begin
        it1.neg[i] <= in_item.comp[i][31];
        it1.mag[i] <= in_item.comp[i][31] ? (~in_item.comp[i] + 32'd1) : in_item.comp[i];
        sq1[i] <= $signed(in_item.comp[i]) * $signed(in_item.comp[i]);
      end
    end
  end

  always_comb begin
    it2_next = it1;
    for (int k = 0; k < 2; k++) begin
      len2_next[k] = sq1[3*k] + sq1[3*k+1] + sq1[3*k+2];
      it2_next.ok[k] = it1.ok[k] & (len2_next[k] > LENGTH_EPSILON);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it2 <= it2_next;
      len2 <= len2_next;
    end
  end

  for (genvar j = 0; j < SHIFT_STAGES; j++) begin : g_shift
    localparam int AMT  = 16 >> j;
    localparam int TOPB = 62 - 2 * AMT;
    logic             vi;
    item_t            ti, to;
    logic [1:0][63:0] xi, xo;

    if (j == 0) begin : g_first
      assign vi = vld2;
      assign ti = it2;
      assign xi = len2;
    end else begin : g_rest
      assign vi = vs[j-1];
      assign ti = its[j-1];
      assign xi = ts[j-1];
    end

    always_comb begin
      to = ti;
      for (int k = 0; k < 2; k++) begin
        if (xi[k][63:TOPB] == '0) begin
          xo[k] = xi[k] << (2 * AMT);
          to.shift[k] = ti.shift[k] + 5'(AMT);
        end else begin
          xo[k] = xi[k];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[j] <= 1'b0;
      end else if (en) begin
        vs[j] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        its[j] <= to;
        ts[j] <= xo;
      end
    end
  end

  assign out_valid = vs[SHIFT_STAGES-1];
  assign out_item = its[SHIFT_STAGES-1];
  assign rad = ts[SHIFT_STAGES-1];

endmodule

// ----- hdl/vbt_sqrt.sv -----
// Pipelined integer square root, one result bit per stage, two lanes.
// Depends on vbt_pkg for the stage count and the carried item type.
module vbt_sqrt (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  vbt_pkg::item_t    in_item,
  input  logic [1:0][63:0]  rad,
  output logic              out_valid,
  output vbt_pkg::item_t    out_item,
  output logic [1:0][31:0]  root
);
  import vbt_pkg::*;

  logic [SQRT_STAGES-1:0] vs;
  item_t                  its [SQRT_STAGES];
  logic [1:0][63:0]       xs  [SQRT_STAGES];
  logic [1:0][63:0]       rs  [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic             vi;
    item_t            ti;
    logic [1:0][63:0] xi, ri, xo, ro;

    if (k == 0) begin : g_first
      assign vi = in_valid;
      assign ti = in_item;
      assign xi = rad;
      assign ri = '0;
    end else begin : g_rest
      assign vi = vs[k-1];
      assign ti = its[k-1];
      assign xi = xs[k-1];
      assign ri = rs[k-1];
    end

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        if (xi[l] >= ri[l] + BIT) begin
          xo[l] = xi[l] - (ri[l] + BIT);
          ro[l] = (ri[l] >> 1) + BIT;
        end else begin
          xo[l] = xi[l];
          ro[l] = ri[l] >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[k] <= 1'b0;
      end else if (en) begin
        vs[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        its[k] <= ti;
        xs[k] <= xo;
        rs[k] <= ro;
      end
    end
  end

  assign out_valid = vs[SQRT_STAGES-1];
  assign out_item = its[SQRT_STAGES-1];
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      root[l] = rs[SQRT_STAGES-1][l][31:0];
    end
  end

endmodule

// ----- hdl/vbt_div.sv -----
// Scaled rounding numerators and a restoring divider, one quotient bit per stage.
// Depends on vbt_pkg; six lanes, three per vector.
module vbt_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  vbt_pkg::item_t                     in_item,
  input  logic [1:0][31:0]                   root,
  output logic                               out_valid,
  output vbt_pkg::item_t                     out_item,
  output logic [5:0][vbt_pkg::QUOT_W-1:0]    quot
);
  import vbt_pkg::*;

  logic                   vp;
  item_t                  itp;
  logic [5:0][NUM_W-1:0]  remp;
  logic [5:0][31:0]       denp;

  logic [QUOT_W-1:0]      vs;
  item_t                  its [QUOT_W];
  logic [5:0][NUM_W-1:0]  rems [QUOT_W];
  logic [5:0][31:0]       dens [QUOT_W];
  logic [5:0][QUOT_W-1:0] qs   [QUOT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (en) begin
      vp <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      itp <= in_item;
      for (int l = 0; l < 6; l++) begin
        remp[l] <= (NUM_W'(in_item.mag[l]) << (6'(in_item.shift[l/3]) + 6'd16))
                 + NUM_W'(root[l/3] >> 1);
        denp[l] <= root[l/3];
      end
    end
  end

  for (genvar j = 0; j < QUOT_W; j++) begin : g_stage
    localparam int K = QUOT_W - 1 - j;
    logic                   vi;
    item_t                  ti;
    logic [5:0][NUM_W-1:0]  ri, ro;
    logic [5:0][31:0]       di;
    logic [5:0][QUOT_W-1:0] qi, qo;
    logic [NUM_W-1:0]       dsh [6];

    if (j == 0) begin : g_first
      assign vi = vp;
      assign ti = itp;
      assign ri = remp;
      assign di = denp;
      assign qi = '0;
    end else begin : g_rest
      assign vi = vs[j-1];
      assign ti = its[j-1];
      assign ri = rems[j-1];
      assign di = dens[j-1];
      assign qi = qs[j-1];
    end

    always_comb begin
      qo = qi;
      for (int l = 0; l < 6; l++) begin
        dsh[l] = NUM_W'(di[l]) << K;
        if (ri[l] >= dsh[l]) begin
          ro[l] = ri[l] - dsh[l];
          qo[l][K] = 1'b1;
        end else begin
          ro[l] = ri[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[j] <= 1'b0;
      end else if (en) begin
        vs[j] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        its[j] <= ti;
        rems[j] <= ro;
        dens[j] <= di;
        qs[j] <= qo;
      end
    end
  end

  assign out_valid = vs[QUOT_W-1];
  assign out_item = its[QUOT_W-1];
  assign quot = qs[QUOT_W-1];

endmodule

// ----- hdl/vertex_bake_transform.sv -----
// Vertex transform top level: configuration registers, pipeline, result select and skid.
// Depends on vbt_pkg, vbt_xform, vbt_len, vbt_sqrt, vbt_div and the assertion header.
//
// Input words (action, in_x, in_y, in_z) are taken when in_valid is high and
// in_stall is low; result words (out_x, out_y, out_z, normal_source, saturated)
// are handed over when out_valid is high and out_stall is low. One word may enter
// every cycle while in_stall is low and each word gives exactly one result, in order.
// Each word passes in order through the matrix stages, the squared lengths and
// normalising shift, the square root (one root bit per stage), the dividers
// (one quotient bit per stage) and the result select register. Throughput is
// one word per cycle while the skid register is empty.
// A skid register behind the last stage catches a result when the receiver
// stalls; while it is full the whole pipeline holds and in_stall is high.
// Reset clears all valid bits, empties the skid register and loads the identity
// matrix with no translation and three-component positions.
// Configuration is written through cfg_write, cfg_index and cfg_data; the user must
// write it only while the block is idle, which the block itself does not enforce.
`include "vertex_bake_transform_assert.svh"

module vertex_bake_transform (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          action,
  input  logic signed [31:0]            in_x,
  input  logic signed [31:0]            in_y,
  input  logic signed [31:0]            in_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            out_x,
  output logic signed [31:0]            out_y,
  output logic signed [31:0]            out_z,
  output logic [1:0]                    normal_source,
  output logic                          saturated,
  input  logic                          cfg_write,
  input  logic [vbt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data
);
  import vbt_pkg::*;

  logic [63:0]       pair [NUM_PAIRS];
  logic              two_comp;
  logic [11:0][31:0] coef;
  logic              en;

  logic              xf_valid, len_valid, sq_valid, dv_valid;
  xf_t               xf_item;
  item_t             len_item, sq_item, dv_item;
  logic [1:0][63:0]  rad;
  logic [1:0][31:0]  root;
  logic [5:0][QUOT_W-1:0] quot;
  logic [5:0][31:0]  sgn;

  result_t           fin_next, fin, skd, shown;
  logic              fin_valid, skid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair[0] <= COEF_RESET_DIAG;
      pair[1] <= '0;
      pair[2] <= COEF_RESET_DIAG;
      pair[3] <= '0;
      pair[4] <= COEF_RESET_DIAG;
      pair[5] <= '0;
      two_comp <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_PAIR_0:   pair[0] <= cfg_data;
        CFG_PAIR_1:   pair[1] <= cfg_data;
        CFG_PAIR_2:   pair[2] <= cfg_data;
        CFG_PAIR_3:   pair[3] <= cfg_data;
        CFG_PAIR_4:   pair[4] <= cfg_data;
        CFG_PAIR_5:   pair[5] <= cfg_data;
        CFG_TWO_COMP: two_comp <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_PAIRS; i++) begin
      coef[2*i] = pair[i][31:0];
      coef[2*i+1] = pair[i][63:32];
    end
  end

  assign en = !skid_full;
  assign in_stall = skid_full;

  vbt_xform u_xform (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid), .action(action),
    .in_x(in_x), .in_y(in_y), .in_z(in_z), .coef(coef), .two_comp(two_comp),
    .out_valid(xf_valid), .out_item(xf_item)
  );

  vbt_len u_len (
    .clk(clk), .rst(rst), .en(en), .in_valid(xf_valid), .in_item(xf_item),
    .out_valid(len_valid), .out_item(len_item), .rad(rad)
  );

  vbt_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(len_valid), .in_item(len_item),
    .rad(rad), .out_valid(sq_valid), .out_item(sq_item), .root(root)
  );

  vbt_div u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(sq_valid), .in_item(sq_item),
    .root(root), .out_valid(dv_valid), .out_item(dv_item), .quot(quot)
  );

  always_comb begin
    for (int l = 0; l < 6; l++) begin
      sgn[l] = dv_item.neg[l] ? (~32'(quot[l]) + 32'd1) : 32'(quot[l]);
    end
    fin_next.is_normal = (dv_item.action != ACT_POSITION);
    if (dv_item.action == ACT_POSITION) begin
      fin_next.x = dv_item.pos[0];
      fin_next.y = dv_item.pos[1];
      fin_next.z = dv_item.pos[2];
      fin_next.src = SRC_XFORM;
      fin_next.sat = dv_item.sat;
    end else if (dv_item.ok[0]) begin
      fin_next.x = sgn[0];
      fin_next.y = sgn[1];
      fin_next.z = sgn[2];
      fin_next.src = SRC_XFORM;
      fin_next.sat = 1'b0;
    end else if (dv_item.ok[1]) begin
      fin_next.x = sgn[3];
      fin_next.y = sgn[4];
      fin_next.z = sgn[5];
      fin_next.src = SRC_INPUT;
      fin_next.sat = 1'b0;
    end else begin
      fin_next.x = '0;
      fin_next.y = '0;
      fin_next.z = Q16_ONE;
      fin_next.src = SRC_DEFAULT;
      fin_next.sat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (en) begin
      fin_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin <= fin_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (!out_stall) begin
        skid_full <= 1'b0;
      end
    end else if (fin_valid && out_stall) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full) begin
      skd <= fin;
    end
  end

  assign shown = skid_full ? skd : fin;
  assign out_valid = skid_full | fin_valid;
  assign out_x = shown.x;
  assign out_y = shown.y;
  assign out_z = shown.z;
  assign normal_source = shown.src;
  assign saturated = shown.sat;

  `VBT_ASSERT_NOW(a_pos_source, out_valid && !shown.is_normal, normal_source == SRC_XFORM)
  `VBT_ASSERT_NOW(a_normal_unsat, out_valid && shown.is_normal, !saturated)
  `VBT_ASSERT_NOW(a_skid_fill, $rose(skid_full), $past(fin_valid && out_stall))
  `VBT_ASSERT_NEXT(a_skid_hold, skid_full && out_stall, skid_full && $stable(skd))

endmodule

// ----- verif/tb_vertex_bake_transform.sv -----
// Self-checking testbench for vertex_bake_transform: a scoreboard predicts every result.
// It checks positions and normals over a series of matrix settings under random idling.
// Depends on vbt_pkg and the vertex_bake_transform RTL.
`timescale 1ns / 1ps

module tb_vertex_bake_transform;
  import vbt_pkg::*;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [1:0]  src;
    logic        sat;
  } vertex_out_t;

  class vertex_scoreboard;
    logic [63:0] coef[6];
    bit          two_comp;
    vertex_out_t expected_q[$];
    int          errors;

    function void load_reset();
      coef[0] = COEF_RESET_DIAG;
      coef[1] = 64'd0;
      coef[2] = COEF_RESET_DIAG;
      coef[3] = 64'd0;
      coef[4] = COEF_RESET_DIAG;
      coef[5] = 64'd0;
      two_comp = 0;
      errors = 0;
    endfunction

    function logic signed [95:0] half(int k);
      logic signed [31:0] h;
      h = k[0] ? coef[k / 2][63:32] : coef[k / 2][31:0];
      return h;
    endfunction

    // Exact sum of products, rounded to Q16.16 with ties toward plus infinity.
    function logic signed [95:0] row_dot(int r, logic signed [95:0] v0,
                                         logic signed [95:0] v1, logic signed [95:0] v2);
      logic signed [95:0] acc;
      acc = half(r) * v0 + half(3 + r) * v1 + half(6 + r) * v2;
      return (acc + 96'sd32768) >>> 16;
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function bit unit_scale(logic signed [63:0] v[3], output logic [31:0] res[3]);
      logic [63:0] len2;
      logic [63:0] t;
      logic [63:0] len;
      logic [63:0] mag;
      logic [63:0] num;
      logic [63:0] q;
      int          s;
      len2 = 0;
      for (int i = 0; i < 3; i++) len2 = len2 + 64'(v[i] * v[i]);
      if (len2 <= LENGTH_EPSILON) return 0;
      t = len2;
      s = 0;
      while (t < (64'd1 << 60)) begin
        t = t << 2;
        s++;
      end
      len = int_sqrt(t);
      if (len == 0) return 0;
      for (int i = 0; i < 3; i++) begin
        mag = v[i] < 0 ? -v[i] : v[i];
        num = mag << (s + 16);
        q = (num + len / 2) / len;
        res[i] = v[i] < 0 ? 32'(-q) : q[31:0];
      end
      return 1;
    endfunction

    function void note(logic act, logic signed [31:0] x, logic signed [31:0] y,
                       logic signed [31:0] z);
      vertex_out_t        e;
      logic signed [95:0] s;
      logic signed [95:0] d[3];
      logic signed [63:0] dv[3];
      logic signed [63:0] iv[3];
      logic [31:0]        r[3];
      bit                 ok;
      e.src = SRC_XFORM;
      e.sat = 0;
      if (act == ACT_POSITION) begin
        if (two_comp) z = 0;
        for (int i = 0; i < 3; i++) begin
          s = row_dot(i, x, y, z) + half(9 + i);
          if (s > 96'sh7fffffff) begin
            s = 96'sh7fffffff;
            e.sat = 1;
          end else if (s < -96'sh80000000) begin
            s = -96'sh80000000;
            e.sat = 1;
          end
          r[i] = s[31:0];
        end
      end else begin
        ok = 1;
        for (int i = 0; i < 3; i++) begin
          d[i] = row_dot(i, x, y, z);
          if (d[i] > 96'sh7fffffff || d[i] < -96'sh80000000) ok = 0;
          dv[i] = d[i][63:0];
        end
        iv[0] = x;
        iv[1] = y;
        iv[2] = z;
        if (ok && unit_scale(dv, r)) begin
          e.src = SRC_XFORM;
        end else if (unit_scale(iv, r)) begin
          e.src = SRC_INPUT;
        end else begin
          r[0] = 0;
          r[1] = 0;
          r[2] = Q16_ONE;
          e.src = SRC_DEFAULT;
        end
      end
      e.x = r[0];
      e.y = r[1];
      e.z = r[2];
      expected_q.push_back(e);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch on %s: got %h, expected %h", what, got, want);
    endtask

    task check(vertex_out_t got);
      vertex_out_t e;
      if (expected_q.size() == 0) begin
        report("unexpected word", got.x, 0);
        return;
      end
      e = expected_q.pop_front();
      if (got.x !== e.x) report("out_x", got.x, e.x);
      if (got.y !== e.y) report("out_y", got.y, e.y);
      if (got.z !== e.z) report("out_z", got.z, e.z);
      if (got.src !== e.src) report("normal_source", got.src, e.src);
      if (got.sat !== e.sat) report("saturated", got.sat, e.sat);
    endtask
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_stall;
  logic               action = 0;
  logic signed [31:0] in_x = 0;
  logic signed [31:0] in_y = 0;
  logic signed [31:0] in_z = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic [1:0]         normal_source;
  logic               saturated;
  logic               cfg_write = 0;
  logic [CFG_IDX_W-1:0] cfg_index = 0;
  logic [63:0]        cfg_data = 0;

  vertex_scoreboard sb = new();
  bit               calm = 0;

  vertex_bake_transform u_top (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note(action, in_x, in_y, in_z);
    if (!rst && out_valid && !out_stall)
      sb.check('{out_x, out_y, out_z, normal_source, saturated});
  end

  initial begin
    int left;
    bit hold;
    left = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (calm) begin
        out_stall <= 0;
      end else begin
        if (left == 0) begin
          hold = $urandom_range(0, 2) == 0;
          left = $urandom_range(1, 17);
        end
        left--;
        out_stall <= hold;
      end
    end
  end

  task write_reg(cfg_idx_t idx, logic [63:0] value);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 0;
    @(posedge clk);
    if (idx == CFG_TWO_COMP) sb.two_comp = value[0];
    else sb.coef[idx] = value;
  endtask

  task send_vertex(logic act, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1;
    action <= act;
    in_x <= x;
    in_y <= y;
    in_z <= z;
    do @(posedge clk); while (in_stall);
  endtask

  task drain();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  function logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 12) - 6;
      2: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      3: case ($urandom_range(0, 3))
           0: return 32'h8000_0000;
           1: return 32'h7fff_ffff;
           2: return 32'hffff_ffff;
           default: return 0;
         endcase
      4: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      default: return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
    endcase
  endfunction

  function logic [31:0] pick_coef(int style);
    case (style)
      0: return 0;
      1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      2: return $urandom;
      3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return $urandom_range(0, 64) - 32;
    endcase
  endfunction

  initial begin
    int          style;
    logic [31:0] nz;
    repeat (11) @(posedge clk);
    rst <= 0;
    sb.load_reset();
    @(posedge clk);

    send_vertex(ACT_POSITION, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
    send_vertex(ACT_POSITION, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    send_vertex(!ACT_POSITION, 0, 0, 0);
    send_vertex(!ACT_POSITION, 1, 1, 1);
    send_vertex(!ACT_POSITION, 6, 0, 0);
    send_vertex(!ACT_POSITION, 0, 7, 0);
    send_vertex(!ACT_POSITION, 32'h0003_0000, 32'h0004_0000, 0);
    send_vertex(!ACT_POSITION, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vertex(!ACT_POSITION, 32'h7fff_ffff, 0, 32'h8000_0000);
    send_vertex(!ACT_POSITION, 32'hffff_ffff, 32'h0000_0001, 32'hffff_fffc);
    in_valid <= 0;
    drain();
    for (int k = 0; k < 6; k++) write_reg(cfg_idx_t'(k), {32'h8000_0000, 32'h7fff_ffff});
    write_reg(CFG_TWO_COMP, 64'd1);
    send_vertex(ACT_POSITION, 32'h7fff_ffff, 32'h7fff_ffff, 32'h1234_5678);
    send_vertex(ACT_POSITION, 32'h8000_0000, 32'h7fff_ffff, 0);
    send_vertex(ACT_POSITION, 0, 0, 32'h8000_0000);
    send_vertex(!ACT_POSITION, 32'h0001_0000, 32'h0001_0000, 0);
    send_vertex(!ACT_POSITION, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    in_valid <= 0;

    for (int phase = 0; phase < 12; phase++) begin
      drain();
      style = phase % 5;
      for (int k = 0; k < 6; k++)
        write_reg(cfg_idx_t'(k), {pick_coef(style), pick_coef(style)});
      write_reg(CFG_TWO_COMP, phase % 3 == 1);
      calm = phase == 11;
      for (int n = 0; n < 125; n++) begin
        if ($urandom_range(0, 4) == 0) begin
          nz = $urandom_range(0, 8) - 4;
          send_vertex(!ACT_POSITION, $urandom_range(0, 8) - 4, nz, $urandom_range(0, 8) - 4);
        end else begin
          send_vertex($urandom_range(0, 1), pick_value(), pick_value(), pick_value());
        end
      end
      in_valid <= 0;
    end
    drain();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
